>>> hw/rtl/adc_position_conditioner_unit_assert.svh
// Assertion macros shared by the position conditioner RTL.
`ifndef ADC_POSITION_CONDITIONER_UNIT_ASSERT_SVH
`define ADC_POSITION_CONDITIONER_UNIT_ASSERT_SVH

// Condition must hold on every clock edge outside reset.
`define APCU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define APCU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define APCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/apcu_pkg.sv
// Shared types and constants of the ADC position conditioner.
package apcu_pkg;

	localparam int unsigned SAMPLE_BITS_DEF = 12;
	localparam int unsigned RAW_W           = 12;

	localparam logic [16:0] Q16_ONE    = 17'h10000;
	localparam logic [21:0] VEL_LIMIT  = 22'd1000000;
	localparam logic [13:0] ROM_SCALE  = 14'd10000;
	localparam logic [13:0] MS_PER_S   = 14'd1000;
	localparam logic [8:0]  ALPHA_ONE  = 9'd256;
	localparam logic [4:0]  NORM_ITERS = 5'd17;
	localparam logic [4:0]  VEL_ITERS  = 5'd22;

	// register reset values
	localparam logic [15:0] RST_INTERVAL = 16'd10;
	localparam logic [8:0]  RST_ALPHA    = 9'd64;
	localparam logic        RST_AUTO     = 1'b1;
	localparam logic        RST_INVERT   = 1'b0;
	localparam logic [11:0] RST_STROKE   = 12'd500;
	localparam logic [11:0] RST_CAL_LO   = 12'd0;
	localparam logic [11:0] RST_CAL_HI   = 12'd4095;

	typedef enum logic [2:0] {
		REG_INTERVAL,
		REG_ALPHA,
		REG_AUTO,
		REG_INVERT,
		REG_STROKE,
		REG_CAL_LO,
		REG_CAL_HI
	} reg_idx_t;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	// command to the serial arithmetic unit
	typedef struct packed {
		logic               start;
		alu_op_t            op;
		logic signed [31:0] mul_a;
		logic [13:0]        mul_b;
		logic [31:0]        div_rem;
		logic [21:0]        div_dvd;
		logic [31:0]        div_den;
		logic [4:0]         div_iters;
	} alu_ctl_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [31:0] product;
		logic [21:0]        quotient;
	} alu_stat_t;

endpackage

>>> hw/rtl/apcu_serial_alu.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
module apcu_serial_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  apcu_pkg::alu_ctl_t  ctl,
	output apcu_pkg::alu_stat_t stat
);

	logic               busy_q;
	logic               done_q;
	apcu_pkg::alu_op_t  op_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] a_q;
	logic [13:0]        b_q;
	logic [31:0]        rem_q;
	logic [31:0]        den_q;
	logic [21:0]        dvd_q;
	logic [21:0]        quo_q;
	logic [4:0]         cnt_q;

	logic [32:0] rem_sh;
	logic [32:0] rem_diff;
	logic        rem_ge;

	always_comb begin
		rem_sh   = {rem_q, dvd_q[21]};
		rem_diff = rem_sh - {1'b0, den_q};
		rem_ge   = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= apcu_pkg::ALU_MUL;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			dvd_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				acc_q  <= '0;
				a_q    <= ctl.mul_a;
				b_q    <= ctl.mul_b;
				rem_q  <= ctl.div_rem;
				den_q  <= ctl.div_den;
				dvd_q  <= ctl.div_dvd;
				quo_q  <= '0;
				cnt_q  <= ctl.div_iters;
			end else if (busy_q) begin
				case (op_q)
					apcu_pkg::ALU_MUL: begin
						if (b_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else begin
							if (b_q[0])
								acc_q <= acc_q + a_q;
							a_q <= a_q <<< 1;
							b_q <= b_q >> 1;
						end
					end
					apcu_pkg::ALU_DIV: begin
						if (cnt_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else begin
							rem_q <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
							quo_q <= {quo_q[20:0], rem_ge};
							dvd_q <= {dvd_q[20:0], 1'b0};
							cnt_q <= cnt_q - 5'd1;
						end
					end
					default: busy_q <= 1'b0;
				endcase
			end
		end
	end

	always_comb begin
		stat.busy     = busy_q;
		stat.done     = done_q;
		stat.product  = acc_q;
		stat.quotient = quo_q;
	end

endmodule

>>> hw/rtl/adc_position_conditioner_unit.sv
// Top level of the ADC position conditioner: EMA filter, auto-range, position and velocity.
//
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid/s_tready         now_ms, raw_sample
// m_*       out        m_tvalid/m_tready         sample_taken in tuser, results in tdata
// apb       in/out     psel/penable/pwrite       7 registers at byte address 4*index
//
// A taken sample spends nearly all of its processing in the shared bit-serial
// multiply/divide unit (one bit per cycle): one filter multiply, two 17-step
// normalizing divides (skipped when the result clamps), three scale multiplies,
// a velocity multiply and a 22-step velocity divide; multiply length follows the
// multiplier bits (alpha, stroke). An ignored sample (too soon after the last one)
// passes through the done state to the output register without using that unit.
// One sample is in flight at a time; the output register holds a finished
// transaction so the next sample can be taken while the sink stalls.
// Reset clears all state at once; there is no clearing pass.
`include "adc_position_conditioner_unit_assert.svh"

module adc_position_conditioner_unit #(
	parameter int unsigned SAMPLE_BITS = apcu_pkg::SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [31:0] now_ms, [43:32] raw_sample, rest zero
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [19:0] filtered_value, [39:20] position,
	                               // [53:40] rom_percent_instant, [67:54] rom_percent,
	                               // [88:68] velocity (signed), rest zero
	output logic [0:0]  m_tuser,   // [0] sample_taken
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Only the low SAMPLE_BITS of the converter word are meaningful.
	localparam int unsigned RawKeep =
		(SAMPLE_BITS < apcu_pkg::RAW_W) ? SAMPLE_BITS : apcu_pkg::RAW_W;
	localparam logic [11:0] RawMask = 12'((33'd1 << RawKeep) - 33'd1);

	typedef enum logic [4:0] {
		S_IDLE,
		S_FILT_START,
		S_FILT_WAIT,
		S_RANGE,
		S_SPAN,
		S_NI_START,
		S_NI_WAIT,
		S_NF_START,
		S_NF_WAIT,
		S_POS_START,
		S_POS_WAIT,
		S_RI_START,
		S_RI_WAIT,
		S_RF_START,
		S_RF_WAIT,
		S_VM_START,
		S_VM_WAIT,
		S_VD_START,
		S_VD_WAIT,
		S_DONE
	} state_t;

	function automatic logic [16:0] orient(input logic [16:0] n, input logic flip);
		orient = flip ? (apcu_pkg::Q16_ONE - n) : n;
	endfunction

	// configuration registers
	logic [15:0] interval_q;
	logic [8:0]  alpha_q;
	logic        auto_q;
	logic        inv_q;
	logic [11:0] stroke_q;
	logic [11:0] cal_lo_q;
	logic [11:0] cal_hi_q;

	// sequencer and per-sample working state
	state_t      state_q;
	logic [31:0] last_time_q;
	logic [19:0] filt_q;
	logic        seeded_q;
	logic [11:0] min_q;
	logic [11:0] max_q;
	logic [19:0] last_pos_q;
	logic [11:0] raw_q;
	logic [31:0] dt_q;
	logic        taken_q;
	logic [11:0] span_q;
	logic [16:0] n_i_q;
	logic [16:0] n_f_q;
	logic [19:0] pos_q;
	logic [13:0] rom_i_q;
	logic [13:0] rom_f_q;
	logic [20:0] vel_q;
	logic        neg_q;

	apcu_pkg::alu_ctl_t  alu_ctl;
	apcu_pkg::alu_stat_t alu_stat;

	apcu_pkg::reg_idx_t reg_idx;
	logic               apb_wr;
	logic [11:0]        cal_lo_nx;
	logic [11:0]        cal_hi_nx;
	logic [11:0]        cal_min_nx;
	logic [11:0]        cal_max_nx;

	logic [31:0]        in_now;
	logic [11:0]        in_raw;
	logic [31:0]        dt;
	logic               skip;
	logic [8:0]         alpha_sat;
	logic [11:0]        stroke_eff;
	logic [11:0]        trunc;

	logic [19:0]        norm_x;
	logic signed [20:0] norm_num;
	logic               norm_pos;
	logic [27:0]        norm_dvd;
	logic               norm_ovf;
	logic [16:0]        norm_fast;
	logic [16:0]        q17;
	logic [16:0]        div_n;

	logic signed [20:0] filt_diff;
	logic signed [31:0] filt_step;
	logic signed [31:0] filt_sum;
	logic [19:0]        filt_new;

	logic [31:0]        prod_u;
	logic [31:0]        prod_rnd8;
	logic [31:0]        prod_rnd16;

	logic signed [20:0] vel_diff;
	logic [20:0]        vel_abs;
	logic [21:0]        vel_lim;
	logic [20:0]        vel_new;

	assign pready   = 1'b1;
	assign s_tready = (state_q == S_IDLE);

	// register access: index is the word address, byte offset ignored
	always_comb begin
		reg_idx    = apcu_pkg::reg_idx_t'(paddr[4:2]);
		apb_wr     = psel & penable & pwrite & pready;
		cal_lo_nx  = (reg_idx == apcu_pkg::REG_CAL_LO) ? pwdata[11:0] : cal_lo_q;
		cal_hi_nx  = (reg_idx == apcu_pkg::REG_CAL_HI) ? pwdata[11:0] : cal_hi_q;
		cal_min_nx = (cal_lo_nx < cal_hi_nx) ? cal_lo_nx : cal_hi_nx;
		cal_max_nx = (cal_lo_nx < cal_hi_nx) ? cal_hi_nx : cal_lo_nx;
	end

	always_comb begin
		case (reg_idx)
			apcu_pkg::REG_INTERVAL: prdata = {16'b0, interval_q};
			apcu_pkg::REG_ALPHA:    prdata = {23'b0, alpha_q};
			apcu_pkg::REG_AUTO:     prdata = {31'b0, auto_q};
			apcu_pkg::REG_INVERT:   prdata = {31'b0, inv_q};
			apcu_pkg::REG_STROKE:   prdata = {20'b0, stroke_q};
			apcu_pkg::REG_CAL_LO:   prdata = {20'b0, cal_lo_q};
			apcu_pkg::REG_CAL_HI:   prdata = {20'b0, cal_hi_q};
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= apcu_pkg::RST_INTERVAL;
			alpha_q    <= apcu_pkg::RST_ALPHA;
			auto_q     <= apcu_pkg::RST_AUTO;
			inv_q      <= apcu_pkg::RST_INVERT;
			stroke_q   <= apcu_pkg::RST_STROKE;
			cal_lo_q   <= apcu_pkg::RST_CAL_LO;
			cal_hi_q   <= apcu_pkg::RST_CAL_HI;
		end else if (apb_wr) begin
			case (reg_idx)
				apcu_pkg::REG_INTERVAL: interval_q <= pwdata[15:0];
				apcu_pkg::REG_ALPHA:    alpha_q    <= pwdata[8:0];
				apcu_pkg::REG_AUTO:     auto_q     <= pwdata[0];
				apcu_pkg::REG_INVERT:   inv_q      <= pwdata[0];
				apcu_pkg::REG_STROKE:   stroke_q   <= pwdata[11:0];
				apcu_pkg::REG_CAL_LO:   cal_lo_q   <= pwdata[11:0];
				apcu_pkg::REG_CAL_HI:   cal_hi_q   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// input decode and rate gate (time distance wraps modulo 2^32)
	always_comb begin
		in_now     = s_tdata[31:0];
		in_raw     = s_tdata[43:32] & RawMask;
		dt         = in_now - last_time_q;
		skip       = (dt < {16'b0, interval_q});
		alpha_sat  = (alpha_q > apcu_pkg::ALPHA_ONE) ? apcu_pkg::ALPHA_ONE : alpha_q;
		stroke_eff = (stroke_q == '0) ? 12'd1 : stroke_q;
		trunc      = filt_q[19:8];
	end

	// Normalization setup: n = floor((x - min*256) * 256 / span), clamped to 0 .. 1.0.
	// Quotient fits in 17 bits exactly when the top dividend bits stay below span.
	always_comb begin
		norm_x    = (state_q == S_NI_START) ? {raw_q, 8'b0} : filt_q;
		norm_num  = $signed({1'b0, norm_x}) - $signed({1'b0, min_q, 8'b0});
		norm_pos  = !norm_num[20] && (norm_num != '0);
		norm_dvd  = {norm_num[19:0], 8'b0};
		norm_ovf  = ({1'b0, norm_dvd[27:17]} >= span_q);
		norm_fast = norm_pos ? apcu_pkg::Q16_ONE : '0;
		q17       = alu_stat.quotient[16:0];
		div_n     = (q17 > apcu_pkg::Q16_ONE) ? apcu_pkg::Q16_ONE : q17;
	end

	// EMA update written as f + (alpha*(R - f) + 128) >> 8, R = raw << 8
	always_comb begin
		filt_diff = $signed({1'b0, raw_q, 8'b0}) - $signed({1'b0, filt_q});
		filt_step = (alu_stat.product + 32'sd128) >>> 8;
		filt_sum  = filt_step + $signed({12'b0, filt_q});
		filt_new  = filt_sum[19:0];
	end

	always_comb begin
		prod_u     = alu_stat.product;
		prod_rnd8  = prod_u + 32'd128;
		prod_rnd16 = prod_u + 32'd32768;
		vel_diff   = $signed({1'b0, pos_q}) - $signed({1'b0, last_pos_q});
		vel_abs    = vel_diff[20] ? -vel_diff : vel_diff;
		vel_lim    = (alu_stat.quotient > apcu_pkg::VEL_LIMIT) ?
			apcu_pkg::VEL_LIMIT : alu_stat.quotient;
		vel_new    = neg_q ? (21'd0 - vel_lim[20:0]) : vel_lim[20:0];
	end

	// commands to the serial unit, issued from the start states only
	always_comb begin
		alu_ctl = '0;
		case (state_q)
			S_FILT_START: begin
				alu_ctl.start = 1'b1;
				alu_ctl.op    = apcu_pkg::ALU_MUL;
				alu_ctl.mul_a = {{11{filt_diff[20]}}, filt_diff};
				alu_ctl.mul_b = {5'b0, alpha_sat};
			end
			S_NI_START, S_NF_START: begin
				alu_ctl.start     = norm_pos && !norm_ovf;
				alu_ctl.op        = apcu_pkg::ALU_DIV;
				alu_ctl.div_rem   = {21'b0, norm_dvd[27:17]};
				alu_ctl.div_dvd   = {norm_dvd[16:0], 5'b0};
				alu_ctl.div_den   = {20'b0, span_q};
				alu_ctl.div_iters = apcu_pkg::NORM_ITERS;
			end
			S_POS_START: begin
				alu_ctl.start = 1'b1;
				alu_ctl.op    = apcu_pkg::ALU_MUL;
				alu_ctl.mul_a = {15'b0, n_f_q};
				alu_ctl.mul_b = {2'b0, stroke_eff};
			end
			S_RI_START: begin
				alu_ctl.start = 1'b1;
				alu_ctl.op    = apcu_pkg::ALU_MUL;
				alu_ctl.mul_a = {15'b0, n_i_q};
				alu_ctl.mul_b = apcu_pkg::ROM_SCALE;
			end
			S_RF_START: begin
				alu_ctl.start = 1'b1;
				alu_ctl.op    = apcu_pkg::ALU_MUL;
				alu_ctl.mul_a = {15'b0, n_f_q};
				alu_ctl.mul_b = apcu_pkg::ROM_SCALE;
			end
			S_VM_START: begin
				alu_ctl.start = 1'b1;
				alu_ctl.op    = apcu_pkg::ALU_MUL;
				alu_ctl.mul_a = {12'b0, vel_abs[19:0]};
				alu_ctl.mul_b = apcu_pkg::MS_PER_S;
			end
			S_VD_START: begin
				// |diff|*1000/(256*dt) == floor(|diff|*1000/256) / dt
				alu_ctl.start     = 1'b1;
				alu_ctl.op        = apcu_pkg::ALU_DIV;
				alu_ctl.div_rem   = '0;
				alu_ctl.div_dvd   = prod_u[29:8];
				alu_ctl.div_den   = dt_q;
				alu_ctl.div_iters = apcu_pkg::VEL_ITERS;
			end
			default: ;
		endcase
	end

	apcu_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.stat   (alu_stat)
	);

	// sequencer, working state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_time_q <= '0;
			filt_q      <= '0;
			seeded_q    <= 1'b0;
			min_q       <= apcu_pkg::RST_CAL_LO;
			max_q       <= apcu_pkg::RST_CAL_HI;
			last_pos_q  <= '0;
			raw_q       <= '0;
			dt_q        <= '0;
			taken_q     <= 1'b0;
			span_q      <= 12'd1;
			n_i_q       <= '0;
			n_f_q       <= '0;
			pos_q       <= '0;
			rom_i_q     <= '0;
			rom_f_q     <= '0;
			vel_q       <= '0;
			neg_q       <= 1'b0;
			m_tvalid    <= 1'b0;
			m_tuser     <= '0;
			m_tdata     <= '0;
		end else begin
			// in S_DONE the load below handles the handshake itself
			if (m_tvalid && m_tready && state_q != S_DONE)
				m_tvalid <= 1'b0;
			// calibration write reloads the tracked limits
			if (apb_wr && (reg_idx == apcu_pkg::REG_CAL_LO || reg_idx == apcu_pkg::REG_CAL_HI)) begin
				min_q <= cal_min_nx;
				max_q <= cal_max_nx;
			end
			case (state_q)
				S_IDLE: if (s_tvalid) begin
					raw_q <= in_raw;
					if (skip) begin
						taken_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						taken_q     <= 1'b1;
						last_time_q <= in_now;
						dt_q        <= (dt == '0) ? 32'd1 : dt;
						if (seeded_q) begin
							state_q <= S_FILT_START;
						end else begin
							// first sample seeds the filter directly
							filt_q   <= {in_raw, 8'b0};
							seeded_q <= 1'b1;
							state_q  <= S_RANGE;
						end
					end
				end
				S_FILT_START: state_q <= S_FILT_WAIT;
				S_FILT_WAIT: if (alu_stat.done) begin
					filt_q  <= filt_new;
					state_q <= S_RANGE;
				end
				S_RANGE: begin
					if (auto_q) begin
						if (trunc < min_q)
							min_q <= trunc;
						if (trunc > max_q)
							max_q <= trunc;
					end
					state_q <= S_SPAN;
				end
				S_SPAN: begin
					span_q  <= (max_q > min_q) ? (max_q - min_q) : 12'd1;
					state_q <= S_NI_START;
				end
				S_NI_START: begin
					if (alu_ctl.start) begin
						state_q <= S_NI_WAIT;
					end else begin
						n_i_q   <= orient(norm_fast, inv_q);
						state_q <= S_NF_START;
					end
				end
				S_NI_WAIT: if (alu_stat.done) begin
					n_i_q   <= orient(div_n, inv_q);
					state_q <= S_NF_START;
				end
				S_NF_START: begin
					if (alu_ctl.start) begin
						state_q <= S_NF_WAIT;
					end else begin
						n_f_q   <= orient(norm_fast, inv_q);
						state_q <= S_POS_START;
					end
				end
				S_NF_WAIT: if (alu_stat.done) begin
					n_f_q   <= orient(div_n, inv_q);
					state_q <= S_POS_START;
				end
				S_POS_START: state_q <= S_POS_WAIT;
				S_POS_WAIT: if (alu_stat.done) begin
					pos_q   <= prod_rnd8[27:8];
					state_q <= S_RI_START;
				end
				S_RI_START: state_q <= S_RI_WAIT;
				S_RI_WAIT: if (alu_stat.done) begin
					rom_i_q <= prod_rnd16[29:16];
					state_q <= S_RF_START;
				end
				S_RF_START: state_q <= S_RF_WAIT;
				S_RF_WAIT: if (alu_stat.done) begin
					rom_f_q <= prod_rnd16[29:16];
					state_q <= S_VM_START;
				end
				S_VM_START: begin
					neg_q   <= vel_diff[20];
					state_q <= S_VM_WAIT;
				end
				S_VM_WAIT: if (alu_stat.done)
					state_q <= S_VD_START;
				S_VD_START: state_q <= S_VD_WAIT;
				S_VD_WAIT: if (alu_stat.done) begin
					vel_q      <= vel_new;
					last_pos_q <= pos_q;
					state_q    <= S_DONE;
				end
				S_DONE: if (!m_tvalid || m_tready) begin
					m_tvalid <= 1'b1;
					m_tuser  <= taken_q;
					m_tdata  <= taken_q ?
						{7'b0, vel_q, rom_f_q, rom_i_q, pos_q, filt_q} : '0;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`APCU_ASSERT_ALWAYS(a_range_order, clk, arst_n, min_q <= max_q, "tracked min above tracked max")
	`APCU_ASSERT_IMPLIES(a_skip_zero, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata == '0, "ignored sample with nonzero result")
	`APCU_ASSERT_IMPLIES(a_vel_bound, clk, arst_n, m_tvalid && m_tuser[0], ($signed(m_tdata[88:68]) <= 21'sd1000000) && ($signed(m_tdata[88:68]) >= -21'sd1000000), "velocity outside saturation bounds")
	`APCU_ASSERT_IMPLIES(a_alu_free, clk, arst_n, alu_ctl.start, !alu_stat.busy, "serial unit started while busy")
	`APCU_ASSERT_NEXT(a_norm_bound, clk, arst_n, state_q == S_NF_WAIT && alu_stat.done, n_f_q <= apcu_pkg::Q16_ONE, "normalized value above one")

endmodule
